// ----- hw/rtl/pec_pkg.sv -----
package pec_pkg;

    localparam int COORD_WIDTH     = 16;
    // One quotient bit per step; the crossing quotient always fits in COORD_WIDTH + 1 bits.
    localparam int DIV_STEPS       = COORD_WIDTH + 1;
    localparam int CNT_WIDTH       = $clog2(DIV_STEPS);
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EDGE_SELECT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLIP_VALUE  = 2'd1;

    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_TOP    = 2'd1,
        EDGE_RIGHT  = 2'd2,
        EDGE_BOTTOM = 2'd3
    } edge_t;

    typedef enum logic [1:0] {
        EMIT_NONE  = 2'd0,
        EMIT_CROSS = 2'd1,
        EMIT_VERT  = 2'd2,
        EMIT_MARK  = 2'd3
    } emit_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vert_x;
        logic signed [COORD_WIDTH-1:0] vert_y;
        logic                          last_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic                          out_valid;
        logic                          out_last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic  accept;      // capture incoming vertex
        logic  set_first;   // current vertex opens a polygon
        logic  load;        // load edge endpoints and differences
        logic  close_edge;  // 0: prev -> cur, 1: cur -> first
        logic  mul;         // magnitude product, divider init
        logic  div_step;    // one restoring division step
        emit_t emit;
        logic  out_last;
        logic  finish;      // prev <= cur, update polygon state
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic have_first;
        logic last_vertex;
        logic in_cur;
        logic in_first;
        logic in_a;         // loaded edge start inside
        logic in_b;         // loaded edge end inside
        logic out_free;
    } ctl_sts_t;

endpackage

// ----- hw/rtl/pec_ctrl.sv -----
module pec_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pec_pkg::ctl_sts_t sts,
    output pec_pkg::ctl_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LOAD,
        ST_CHECK,
        ST_DIV,
        ST_CROSS,
        ST_VERT,
        ST_EDONE,
        ST_MARK
    } state_t;

    state_t                          state_reg, state_next;
    logic                            close_reg, close_next;
    logic                            emitted_reg, emitted_next;
    logic [pec_pkg::CNT_WIDTH-1:0]   count_reg, count_next;
    logic                            edge_final;

    // last result of this edge is the polygon's last one
    assign edge_final = close_reg || (sts.last_vertex && !(sts.in_cur || sts.in_first));
    assign s_ready    = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        close_next   = close_reg;
        emitted_next = emitted_reg;
        count_next   = count_reg;
        cmd          = '0;
        cmd.emit     = pec_pkg::EMIT_NONE;
        cmd.close_edge = close_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                emitted_next = 1'b0;
                if (sts.have_first) begin
                    close_next = 1'b0;
                    state_next = ST_LOAD;
                end else begin
                    cmd.set_first = 1'b1;
                    if (sts.last_vertex) begin
                        close_next = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.in_a && sts.in_b) begin
                    state_next = ST_VERT;
                end else if (!sts.in_a && !sts.in_b) begin
                    state_next = ST_EDONE;
                end else begin
                    cmd.mul    = 1'b1;
                    count_next = pec_pkg::CNT_WIDTH'(pec_pkg::DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (count_reg == '0) begin
                    state_next = ST_CROSS;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            ST_CROSS: begin
                if (sts.out_free) begin
                    cmd.emit     = pec_pkg::EMIT_CROSS;
                    cmd.out_last = edge_final && !sts.in_b;
                    emitted_next = 1'b1;
                    state_next   = sts.in_b ? ST_VERT : ST_EDONE;
                end
            end
            ST_VERT: begin
                if (sts.out_free) begin
                    cmd.emit     = pec_pkg::EMIT_VERT;
                    cmd.out_last = edge_final;
                    emitted_next = 1'b1;
                    state_next   = ST_EDONE;
                end
            end
            ST_EDONE: begin
                if (!close_reg && sts.last_vertex) begin
                    close_next = 1'b1;
                    state_next = ST_LOAD;
                end else if (sts.last_vertex && !emitted_reg) begin
                    state_next = ST_MARK;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MARK: begin
                if (sts.out_free) begin
                    cmd.emit     = pec_pkg::EMIT_MARK;
                    cmd.out_last = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            close_reg   <= 1'b0;
            emitted_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            close_reg   <= close_next;
            emitted_reg <= emitted_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ----- hw/rtl/pec_datapath.sv -----
module pec_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    input  logic [pec_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pec_pkg::COORD_WIDTH-1:0]        cfg_data,
    input  pec_pkg::vertex_t                       s_payload,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output pec_pkg::result_t                       m_payload,
    input  pec_pkg::ctl_cmd_t                      cmd,
    output pec_pkg::ctl_sts_t                      sts
);

    localparam int W = pec_pkg::COORD_WIDTH;
    localparam int Q = pec_pkg::DIV_STEPS;

    pec_pkg::edge_t          edge_sel_reg;
    logic signed [W-1:0]     clip_reg;

    logic signed [W-1:0]     cur_x_reg, cur_y_reg, prev_x_reg, prev_y_reg;
    logic signed [W-1:0]     first_x_reg, first_y_reg;
    logic                    cur_last_reg, have_first_reg;

    logic signed [W-1:0]     x1_reg, y1_reg, x2_reg, y2_reg, base_reg;
    logic signed [W:0]       d_other_reg, d_clip_reg, d_axis_reg;

    logic [W-1:0]            rem_reg, dmag_reg;
    logic [Q-1:0]            dvd_reg, quot_reg;
    logic                    neg_reg;

    pec_pkg::result_t        m_payload_reg;
    logic                    m_valid_reg;

    logic                    x_axis;
    logic signed [W-1:0]     sx1, sy1, sx2, sy2, a1, a2, o1, o2;
    logic [W-1:0]            mag_other, mag_clip;
    logic [2*W-1:0]          prod;
    logic [W:0]              trial;
    logic                    take;
    logic signed [W-1:0]     cross_val;
    logic                    out_free;

    function automatic logic vert_inside(pec_pkg::edge_t e, logic signed [W-1:0] x,
                                         logic signed [W-1:0] y, logic signed [W-1:0] c);
        logic r;
        unique case (e)
            pec_pkg::EDGE_LEFT:   r = (x >= c);
            pec_pkg::EDGE_TOP:    r = (y >= c);
            pec_pkg::EDGE_RIGHT:  r = (x <= c);
            pec_pkg::EDGE_BOTTOM: r = (y <= c);
            default:              r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [W-1:0] mag(logic signed [W:0] v);
        logic signed [W:0] a;
        a = v[W] ? -v : v;
        return a[W-1:0];
    endfunction

    // left/right boundaries cut across x, top/bottom across y
    assign x_axis = (edge_sel_reg == pec_pkg::EDGE_LEFT) ||
                    (edge_sel_reg == pec_pkg::EDGE_RIGHT);

    assign sx1 = cmd.close_edge ? cur_x_reg   : prev_x_reg;
    assign sy1 = cmd.close_edge ? cur_y_reg   : prev_y_reg;
    assign sx2 = cmd.close_edge ? first_x_reg : cur_x_reg;
    assign sy2 = cmd.close_edge ? first_y_reg : cur_y_reg;
    assign a1  = x_axis ? sx1 : sy1;
    assign a2  = x_axis ? sx2 : sy2;
    assign o1  = x_axis ? sy1 : sx1;
    assign o2  = x_axis ? sy2 : sx2;

    assign mag_other = mag(d_other_reg);
    assign mag_clip  = mag(d_clip_reg);
    assign prod      = {{W{1'b0}}, mag_other} * {{W{1'b0}}, mag_clip};

    assign trial = {rem_reg, dvd_reg[Q-1]};
    assign take  = (trial >= {1'b0, dmag_reg});

    // quotient is below 2^W, so the wrap to W bits matches the reference
    assign cross_val = neg_reg ? (base_reg - $signed(quot_reg[W-1:0]))
                               : (base_reg + $signed(quot_reg[W-1:0]));

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        sts.have_first  = have_first_reg;
        sts.last_vertex = cur_last_reg;
        sts.in_cur      = vert_inside(edge_sel_reg, cur_x_reg, cur_y_reg, clip_reg);
        sts.in_first    = vert_inside(edge_sel_reg, first_x_reg, first_y_reg, clip_reg);
        sts.in_a        = vert_inside(edge_sel_reg, x1_reg, y1_reg, clip_reg);
        sts.in_b        = vert_inside(edge_sel_reg, x2_reg, y2_reg, clip_reg);
        sts.out_free    = out_free;
    end

    // configuration and polygon state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_sel_reg   <= pec_pkg::EDGE_LEFT;
            clip_reg       <= '0;
            have_first_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == pec_pkg::CFG_EDGE_SELECT) begin
                    edge_sel_reg <= pec_pkg::edge_t'(cfg_data[1:0]);
                end else if (cfg_index == pec_pkg::CFG_CLIP_VALUE) begin
                    clip_reg <= cfg_data;
                end
            end
            if (cmd.set_first) begin
                first_x_reg    <= cur_x_reg;
                first_y_reg    <= cur_y_reg;
                have_first_reg <= 1'b1;
            end
            if (cmd.finish) begin
                prev_x_reg     <= cur_x_reg;
                prev_y_reg     <= cur_y_reg;
                have_first_reg <= !cur_last_reg;
            end
        end
    end

    // edge arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cur_x_reg    <= s_payload.vert_x;
            cur_y_reg    <= s_payload.vert_y;
            cur_last_reg <= s_payload.last_vertex;
        end
        if (cmd.load) begin
            x1_reg      <= sx1;
            y1_reg      <= sy1;
            x2_reg      <= sx2;
            y2_reg      <= sy2;
            base_reg    <= o1;
            d_other_reg <= (W+1)'(o2) - (W+1)'(o1);
            d_clip_reg  <= (W+1)'(clip_reg) - (W+1)'(a1);
            d_axis_reg  <= (W+1)'(a2) - (W+1)'(a1);
        end
        if (cmd.mul) begin
            rem_reg  <= W'(prod >> Q);
            dvd_reg  <= prod[Q-1:0];
            quot_reg <= '0;
            dmag_reg <= mag(d_axis_reg);
            neg_reg  <= d_other_reg[W] ^ d_clip_reg[W] ^ d_axis_reg[W];
        end
        if (cmd.div_step) begin
            rem_reg  <= take ? W'(trial - {1'b0, dmag_reg}) : trial[W-1:0];
            dvd_reg  <= {dvd_reg[Q-2:0], 1'b0};
            quot_reg <= {quot_reg[Q-2:0], take};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit != pec_pkg::EMIT_NONE) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.emit)
            pec_pkg::EMIT_CROSS: begin
                m_payload_reg.out_x     <= x_axis ? clip_reg : cross_val;
                m_payload_reg.out_y     <= x_axis ? cross_val : clip_reg;
                m_payload_reg.out_valid <= 1'b1;
                m_payload_reg.out_last  <= cmd.out_last;
            end
            pec_pkg::EMIT_VERT: begin
                m_payload_reg.out_x     <= x2_reg;
                m_payload_reg.out_y     <= y2_reg;
                m_payload_reg.out_valid <= 1'b1;
                m_payload_reg.out_last  <= cmd.out_last;
            end
            pec_pkg::EMIT_MARK: begin
                m_payload_reg.out_x     <= '0;
                m_payload_reg.out_y     <= '0;
                m_payload_reg.out_valid <= 1'b0;
                m_payload_reg.out_last  <= cmd.out_last;
            end
            pec_pkg::EMIT_NONE: begin
                m_payload_reg <= m_payload_reg;
            end
            default: begin
                m_payload_reg <= m_payload_reg;
            end
        endcase
    end

endmodule

// ----- hw/rtl/polygon_edge_clipper_unit.sv -----
// Channel   Direction  Handshake            Beat
// s_        in         s_valid / s_ready    vertex_t: vert_x, vert_y, last_vertex
// m_        out        m_valid / m_ready    result_t: out_x, out_y, out_valid, out_last
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (0 edge_select, 1 clip_value)
//
// One vertex at a time: accept and decode are all a polygon's first vertex needs. Each later
// edge is loaded and checked: both ends outside emit nothing, both inside emit the end vertex,
// one end inside has the divider yield the crossing one quotient bit a cycle, then emit it and
// the end vertex if inside. A last vertex also clips the closing edge; if its edges emit nothing,
// an end marker follows. Reset is synchronous, active low, clears config and polygon state.
// A result waits in the output register; the next vertex is taken while it waits,
// and the controller only stalls when a second beat finds that register still full.
module polygon_edge_clipper_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  pec_pkg::vertex_t                    s_payload,

    output logic                                m_valid,
    input  logic                                m_ready,
    output pec_pkg::result_t                    m_payload,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pec_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pec_pkg::COORD_WIDTH-1:0]     cfg_data
);

    pec_pkg::ctl_cmd_t cmd;
    pec_pkg::ctl_sts_t sts;

    // config writes are to land only while idle (the block does not enforce it); they are always taken
    assign cfg_ready = 1'b1;

    // sequencing: vertex capture, edge setup, divide, emit
    pec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // vertex storage, inside tests, multiply/divide, output register
    pec_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one vertex in flight: an accepted beat closes the input until the vertex is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a vertex is in flight");

    // the controller never loads a beat into a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit != pec_pkg::EMIT_NONE) |-> (!m_valid || m_ready))
        else $error("output register overwritten");

    // an empty end marker always closes the polygon and carries zeros
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.out_valid) |->
            (m_payload.out_last && m_payload.out_x == '0 && m_payload.out_y == '0))
        else $error("malformed end marker");

endmodule
